// File: rtl/window_median_filter_macros.svh
// ----------------------------------------------------------------------------
// window median filter assertion macros
// shared concurrent assertion forms used by the checker
// ----------------------------------------------------------------------------
`ifndef WINDOW_MEDIAN_FILTER_MACROS_SVH
`define WINDOW_MEDIAN_FILTER_MACROS_SVH

// same-cycle implication, off during reset
`define WMF_ASSERT_SAME(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("window median filter check failed");

// next-cycle implication, off during reset
`define WMF_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("window median filter check failed");

// next-cycle implication, also checked across reset
`define WMF_ASSERT_NEXT_ALWAYS(label, clk, a, c) \
    label: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("window median filter check failed");

`endif

// File: rtl/wmf_pkg.sv
// ----------------------------------------------------------------------------
// wmf_pkg
// shared types and constants of the window median filter
// ----------------------------------------------------------------------------
package wmf_pkg;

    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int K_CFG_W    = 3;
    localparam int DIM_CFG_W  = 10;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } wmf_reg_t;

    localparam logic [K_CFG_W-1:0]   K_RESET   = 3'd3;
    localparam logic [DIM_CFG_W-1:0] DIM_RESET = 10'd512;

    // per-item control traveling with the pipeline
    typedef struct packed {
        logic emit;
        logic last;
    } wmf_tag_t;

endpackage

// File: rtl/wmf_ram.sv
// ----------------------------------------------------------------------------
// wmf_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module wmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read returns old data on a same-address write
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/wmf_median.sv
// ----------------------------------------------------------------------------
// wmf_median
// rank-based median: pairwise compare stage, then rank count and select
// ----------------------------------------------------------------------------
module wmf_median #(
    parameter int MAX_WINDOW = 5
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     en,
    input  wmf_pkg::wmf_tag_t                        tag_in,
    input  logic [MAX_WINDOW*MAX_WINDOW*wmf_pkg::PIX_W-1:0] window,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]          k,
    output wmf_pkg::wmf_tag_t                        tag_out,
    output logic [wmf_pkg::PIX_W-1:0]                median
);
    import wmf_pkg::*;

    localparam int N   = MAX_WINDOW * MAX_WINDOW;
    localparam int KW  = $clog2(MAX_WINDOW + 1);
    localparam int RKW = $clog2(N);

    logic [KW-1:0]      base;
    logic [N-1:0]       active;
    logic [N-1:0]       cmp_next [N];
    logic [N-1:0]       cmp_reg  [N];
    logic [N-1:0]       act_reg;
    logic [N*PIX_W-1:0] val_reg;
    wmf_tag_t           tag_reg;
    logic [2*KW-1:0]    kk;
    logic [RKW-1:0]     mid;

    assign base = KW'(MAX_WINDOW) - k;

    always_comb begin
        for (int x = 0; x < N; x++) begin
            active[x] = ((x / MAX_WINDOW) >= int'(base)) &&
                        ((x % MAX_WINDOW) >= int'(base));
        end
        // cmp_next[x][y]: y ranks below x, ties broken by position
        for (int x = 0; x < N; x++) begin
            for (int y = 0; y < N; y++) begin
                cmp_next[x][y] = active[x] && active[y] && (x != y) &&
                    ((window[y*PIX_W +: PIX_W] < window[x*PIX_W +: PIX_W]) ||
                     ((window[y*PIX_W +: PIX_W] == window[x*PIX_W +: PIX_W]) &&
                      (y < x)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag_reg <= '0;
        end else if (en) begin
            tag_reg <= tag_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmp_reg <= cmp_next;
            act_reg <= active;
            val_reg <= window;
        end
    end

    assign kk  = (2*KW)'(k) * (2*KW)'(k);
    assign mid = RKW'(kk >> 1);

    always_comb begin
        median = '0;
        for (int x = 0; x < N; x++) begin
            if (act_reg[x] && (RKW'($countones(cmp_reg[x])) == mid)) begin
                median = median | val_reg[x*PIX_W +: PIX_W];
            end
        end
    end

    assign tag_out = tag_reg;

endmodule

// File: rtl/window_median_filter.sv
// ----------------------------------------------------------------------------
// window_median_filter
// streaming k x k median filter for 8-bit grayscale pixels in raster order
// ----------------------------------------------------------------------------
// Takes one pixel per clock while s_tready is high and gives at most one
// median per clock. A result passes the line store read, window shift and
// pairwise compare registers, with the rank select feeding the output
// register. The line store is one ram of MAX_WIDTH words, each holding the
// MAX_WINDOW-1 pixels above the current column; it is read when a pixel is
// taken and written back from the stage 1 registers while the pipeline
// advances, with a forwarding register for the one-column frame where both
// touch the same word. An output register plus a skid register let the
// input keep flowing while a result waits; s_tready drops only when both
// are full. Outputs exist only where the window anchored at its
// bottom-right pixel fits the frame, so a frame gives (H-k+1) x (W-k+1)
// medians, the last with m_tlast. Configure only while idle; the line store
// needs no clearing after reset.
module window_median_filter #(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512,
    parameter int MAX_WINDOW = 5
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic [wmf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wmf_pkg::CFG_DATA_W-1:0]  cfg_data,
    // pixel input
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel
    // median output
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] median
    output logic                            m_tlast    // frame_end
);
    import wmf_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int KW    = $clog2(MAX_WINDOW + 1);
    localparam int WW0   = ($clog2(MAX_WIDTH + 1) > $clog2(MAX_HEIGHT + 1)) ?
                           $clog2(MAX_WIDTH + 1) : $clog2(MAX_HEIGHT + 1);
    localparam int WW    = ((WW0 > DIM_CFG_W) ? WW0 : DIM_CFG_W) + 1;
    localparam int LINES = MAX_WINDOW - 1;
    localparam int LW    = LINES * PIX_W;
    localparam int NC    = MAX_WINDOW * MAX_WINDOW;

    // configuration registers
    logic [K_CFG_W-1:0]   window_size_reg;
    logic [DIM_CFG_W-1:0] image_width_reg;
    logic [DIM_CFG_W-1:0] image_height_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg  <= K_RESET;
            image_width_reg  <= DIM_RESET;
            image_height_reg <= DIM_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_WINDOW_SIZE:  window_size_reg  <= cfg_data[K_CFG_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data[DIM_CFG_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data[DIM_CFG_W-1:0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // effective sizes: zero acts as one, oversize clamps to the maximum
    logic [WW-1:0] k_ext, w_ext, h_ext, k_eff, w_eff, h_eff;

    always_comb begin
        k_ext = WW'(window_size_reg);
        w_ext = WW'(image_width_reg);
        h_ext = WW'(image_height_reg);
        k_eff = (k_ext == '0) ? WW'(1) :
                (k_ext > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : k_ext;
        w_eff = (w_ext == '0) ? WW'(1) :
                (w_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : w_ext;
        h_eff = (h_ext == '0) ? WW'(1) :
                (h_ext > WW'(MAX_HEIGHT)) ? WW'(MAX_HEIGHT) : h_ext;
    end

    // pipeline advance: everything moves unless the skid register is full
    logic en;
    logic accept;
    logic skid_valid_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;
    assign accept   = s_tvalid && s_tready;

    // position counters of the next pixel
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [WW-1:0] col_w, row_w, col_nx, row_nx;
    wmf_tag_t      tag0;

    always_comb begin
        col_w = WW'(col_reg);
        row_w = WW'(row_reg);
        // counters past a shrunken frame wrap before use
        if (col_w >= w_eff) begin
            col_w = '0;
            row_w = row_w + WW'(1);
        end
        if (row_w >= h_eff) begin
            row_w = '0;
        end
        // emit when this pixel closes a full window inside the frame
        tag0.emit = (k_eff <= w_eff) && (k_eff <= h_eff) &&
                    (row_w + WW'(1) >= k_eff) && (col_w + WW'(1) >= k_eff);
        tag0.last = (row_w + WW'(1) == h_eff) && (col_w + WW'(1) == w_eff);
        col_nx = col_w + WW'(1);
        row_nx = row_w;
        if (col_nx >= w_eff) begin
            col_nx = '0;
            row_nx = row_w + WW'(1);
            if (row_nx >= h_eff) begin
                row_nx = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (accept) begin
            col_reg <= col_nx[CW-1:0];
            row_reg <= row_nx[RW-1:0];
        end
    end

    // stage 1: line store word returns
    logic             p1_valid_reg;
    wmf_tag_t         p1_tag_reg;
    logic [PIX_W-1:0] p1_pix_reg;
    logic [CW-1:0]    p1_addr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (en) begin
            p1_valid_reg <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_tag_reg  <= tag0;
            p1_pix_reg  <= s_tdata;
            p1_addr_reg <= col_w[CW-1:0];
        end
    end

    logic          ram_wr_en;
    logic [LW-1:0] ram_wr_data;
    logic [LW-1:0] ram_rd_data;
    logic [CW-1:0] ram_rd_addr;
    logic [LW-1:0] line_word;
    logic          fwd_hit_reg;
    logic [LW-1:0] fwd_data_reg;

    assign ram_wr_en   = en && p1_valid_reg;
    assign ram_rd_addr = col_w[CW-1:0];

    wmf_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (p1_addr_reg),
        .wr_data (ram_wr_data),
        .rd_en   (en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // same-column read and write in one cycle: forward the written word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_hit_reg <= 1'b0;
        end else if (en) begin
            fwd_hit_reg <= ram_wr_en && accept && (p1_addr_reg == ram_rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fwd_data_reg <= ram_wr_data;
        end
    end

    assign line_word   = fwd_hit_reg ? fwd_data_reg : ram_rd_data;
    // push the new pixel in as the nearest line, oldest line drops out
    assign ram_wr_data = {line_word[LW-PIX_W-1:0], p1_pix_reg};

    // new window column: oldest line on top, current pixel at the bottom
    logic [PIX_W-1:0] vec [MAX_WINDOW];

    always_comb begin
        vec[MAX_WINDOW-1] = p1_pix_reg;
        for (int d = 0; d < LINES; d++) begin
            vec[MAX_WINDOW-2-d] = line_word[d*PIX_W +: PIX_W];
        end
    end

    // window registers shift one column left per pixel
    logic [PIX_W-1:0] win_reg [MAX_WINDOW][MAX_WINDOW];
    wmf_tag_t         p2_tag_reg;

    always_ff @(posedge aclk) begin
        if (en && p1_valid_reg) begin
            for (int i = 0; i < MAX_WINDOW; i++) begin
                for (int j = 0; j < MAX_WINDOW - 1; j++) begin
                    win_reg[i][j] <= win_reg[i][j+1];
                end
                win_reg[i][MAX_WINDOW-1] <= vec[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_tag_reg <= '0;
        end else if (en) begin
            p2_tag_reg <= p1_valid_reg ? p1_tag_reg : '0;
        end
    end

    logic [NC*PIX_W-1:0] win_flat;

    always_comb begin
        for (int i = 0; i < MAX_WINDOW; i++) begin
            for (int j = 0; j < MAX_WINDOW; j++) begin
                win_flat[(i*MAX_WINDOW+j)*PIX_W +: PIX_W] = win_reg[i][j];
            end
        end
    end

    // stages 3 and 4: compare, rank and select
    wmf_tag_t         med_tag;
    logic [PIX_W-1:0] med_value;

    wmf_median #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_median (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .tag_in  (p2_tag_reg),
        .window  (win_flat),
        .k       (k_eff[KW-1:0]),
        .tag_out (med_tag),
        .median  (med_value)
    );

    // output register with skid register behind it
    logic             out_valid_reg;
    logic [PIX_W-1:0] out_data_reg;
    logic             out_last_reg;
    logic [PIX_W-1:0] skid_data_reg;
    logic             skid_last_reg;
    logic             take;
    logic             new_res;

    assign take    = out_valid_reg && m_tready;
    assign new_res = en && med_tag.emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (new_res) begin
            if (!out_valid_reg || take) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take) begin
                out_data_reg <= skid_data_reg;
                out_last_reg <= skid_last_reg;
            end
        end else if (new_res) begin
            if (!out_valid_reg || take) begin
                out_data_reg <= med_value;
                out_last_reg <= med_tag.last;
            end else begin
                skid_data_reg <= med_value;
                skid_last_reg <= med_tag.last;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: rtl/wmf_checker.sv
// ----------------------------------------------------------------------------
// wmf_checker
// port-level checks of the window median filter, bound to the top level
// ----------------------------------------------------------------------------
`include "window_median_filter_macros.svh"

module wmf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // a stalled result holds
    `WMF_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `WMF_ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast))
    // input only backs up behind a pending result
    `WMF_ASSERT_SAME(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid)
    // nothing comes out right after reset
    `WMF_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid && s_tready)

endmodule

bind window_median_filter wmf_checker u_wmf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/sv/window_median_filter_test.sv
// ----------------------------------------------------------------------------
// window_median_filter_test
// checks the streaming median filter against its own line store and window
// model: directed corner frames, clamped register values, then random frames
// with random gaps on the pixel side and random stalls on the median side
// ----------------------------------------------------------------------------
module window_median_filter_test;
    timeunit 1ns;
    timeprecision 1ps;
    import wmf_pkg::*;

    localparam int MAXW    = 512;
    localparam int MAXH    = 512;
    localparam int MAXK    = 5;
    localparam int LAT     = 24;    // cycles allowed after the last median
    localparam int N_RAND  = 400;

    typedef struct packed {
        logic [7:0] median;
        logic       frame_end;
    } median_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;     // [7:0] pixel
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;     // [7:0] median
    logic                  m_tlast;     // frame_end

    // model state of the filter
    logic [K_CFG_W-1:0]   win_reg;
    logic [DIM_CFG_W-1:0] width_reg;
    logic [DIM_CFG_W-1:0] height_reg;
    logic [7:0]           lines [MAXK-1][MAXW];
    logic [7:0]           win [MAXK][MAXK];
    int                   col_cnt;
    int                   row_cnt;

    median_t expected_medians [$];
    int      fail_count;
    int      pixels_sent;
    bit      src_idle_on;
    bit      sink_idle_on;

    window_median_filter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic int clamp_dim(int v, int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the model by one accepted pixel, queue the median it yields
    function automatic void predict_median(logic [7:0] px);
        int         k, w, h, col, row, base, m, i, j;
        logic [7:0] vec [MAXK];
        logic [7:0] cells [MAXK*MAXK];
        logic [7:0] x;
        median_t    r;
        k   = clamp_dim(win_reg, MAXK);
        w   = clamp_dim(width_reg, MAXW);
        h   = clamp_dim(height_reg, MAXH);
        col = col_cnt;
        row = row_cnt;
        // counters beyond a shrunken frame wrap first
        if (col >= w) begin
            col = 0;
            row++;
        end
        if (row >= h) row = 0;
        if (col >= MAXW) col = MAXW - 1;
        // new window column, oldest line on top
        vec[MAXK-1] = px;
        for (i = 0; i < MAXK - 1; i++) vec[MAXK-2-i] = lines[i][col];
        for (i = MAXK - 2; i > 0; i--) lines[i][col] = lines[i-1][col];
        lines[0][col] = px;
        for (i = 0; i < MAXK; i++) begin
            for (j = 0; j < MAXK - 1; j++) win[i][j] = win[i][j+1];
            win[i][MAXK-1] = vec[i];
        end
        if (k <= w && k <= h && row + 1 >= k && col + 1 >= k) begin
            base = MAXK - k;
            m    = 0;
            // insertion sort of the k x k window
            for (i = base; i < MAXK; i++) begin
                for (j = base; j < MAXK; j++) begin
                    x = win[i][j];
                    r.median = 0;
                    begin : ins
                        int p;
                        p = m;
                        while (p > 0 && cells[p-1] > x) begin
                            cells[p] = cells[p-1];
                            p--;
                        end
                        cells[p] = x;
                    end
                    m++;
                end
            end
            r.median    = cells[m/2];
            r.frame_end = (row + 1 == h && col + 1 == w);
            expected_medians.push_back(r);
        end
        col++;
        if (col >= w) begin
            col = 0;
            row++;
            if (row >= h) row = 0;
        end
        col_cnt = col;
        row_cnt = row;
    endfunction

    // one pixel transaction, entered and left at a falling edge
    task automatic send_pixel(input logic [7:0] px);
        int gap;
        gap = src_idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= px;
        do @(posedge aclk); while (!s_tready);
        predict_median(px);
        pixels_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input wmf_reg_t idx, input int value);
        s_tvalid  <= 1'b0;
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_WINDOW_SIZE:  win_reg    = value[K_CFG_W-1:0];
            REG_IMAGE_WIDTH:  width_reg  = value[DIM_CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_reg = value[DIM_CFG_W-1:0];
            default: ;
        endcase
    endtask

    // wait for every queued median, then for the pipeline to empty
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_medians.size() != 0) @(negedge aclk);
        repeat (LAT) @(negedge aclk);
    endtask

    task automatic set_frame(input int k, input int w, input int h);
        write_reg(REG_WINDOW_SIZE, k);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
    endtask

    // pixel picker: mostly uniform, sometimes the extremes
    function automatic logic [7:0] pick_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic send_frame(input int n_px);
        for (int i = 0; i < n_px; i++) send_pixel(pick_pixel());
        drain();
    endtask

    // window 1 on a single pixel, window 0 acting as 1, extreme pixels
    task automatic test_tiny_frames();
        set_frame(1, 1, 1);
        send_pixel(8'h00);
        send_pixel(8'hff);
        drain();
        write_reg(REG_WINDOW_SIZE, 0);
        send_pixel(8'h5a);
        drain();
        // width and height zero act as one
        set_frame(1, 0, 0);
        send_pixel(8'ha5);
        drain();
    endtask

    // full 5x5 window on a 5x5 frame, checkerboard of extremes
    task automatic test_full_window();
        set_frame(5, 5, 5);
        for (int i = 0; i < 25; i++) send_pixel(i[0] ? 8'hff : 8'h00);
        drain();
    endtask

    // window larger than the frame gives no medians, counters still wrap; then a fitting 3x3 window
    task automatic test_window_too_big();
        set_frame(5, 3, 2);
        send_frame(6);
        set_frame(3, 3, 3);
        send_frame(9);
    endtask

    // register values above the maximum clamp to it
    task automatic test_clamped_sizes();
        set_frame(1, 1023, 1);
        send_frame(MAXW);
        set_frame(7, 1, 1023);
        send_frame(MAXH);
        set_frame(6, 6, 6);
        send_frame(36);
    endtask

    task automatic test_random_frames();
        int k, w, h, start;
        start = pixels_sent;
        while (pixels_sent - start < N_RAND) begin
            k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 5);
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 24);
            src_idle_on  = ($urandom_range(0, 3) != 0);
            sink_idle_on = ($urandom_range(0, 3) != 0);
            set_frame(k, w, h);
            send_frame(w * h);
        end
    endtask

    // median side: random stall before each transaction
    initial begin
        int gap;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            gap = sink_idle_on ? $urandom_range(0, 17) : 0;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // compare every median transaction with the oldest expectation
    always @(posedge aclk) begin
        median_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_medians.size() == 0) begin
                $error("unexpected median transaction: median %0d", m_tdata);
                fail_count++;
            end else begin
                e = expected_medians.pop_front();
                if (m_tdata !== e.median) begin
                    $error("median: expected %0d, got %0d", e.median, m_tdata);
                    fail_count++;
                end
                if (m_tlast !== e.frame_end) begin
                    $error("frame_end: expected %0d, got %0d", e.frame_end, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_index    = REG_WINDOW_SIZE;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        fail_count   = 0;
        pixels_sent  = 0;
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        win_reg      = K_RESET;
        width_reg    = DIM_RESET;
        height_reg   = DIM_RESET;
        col_cnt      = 0;
        row_cnt      = 0;
        foreach (lines[i, j]) lines[i][j] = '0;
        foreach (win[i, j]) win[i][j] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_tiny_frames();
        test_full_window();
        test_window_too_big();
        test_clamped_sizes();
        test_random_frames();
        drain();

        if (fail_count == 0 && expected_medians.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/wmf_pkg.sv
rtl/wmf_ram.sv
rtl/wmf_median.sv
rtl/window_median_filter.sv
rtl/wmf_checker.sv
tb/sv/window_median_filter_test.sv
